### rtl/core/rbpm_pkg.sv
`default_nettype none

package rbpm_pkg;

   // Buffer geometry (depth must be a power of two for pointer wrap)
   localparam int BUF_DEPTH   = 512;
   localparam int ADDR_W      = $clog2(BUF_DEPTH);
   localparam int CNT_W       = 9;
   localparam int MAX_PATTERN = 8;
   localparam int MAX_CHUNK   = 64;

   localparam logic [CNT_W-1:0] FULL_LEVEL   = CNT_W'(BUF_DEPTH - 1);
   localparam logic [7:0]       NEWLINE_CODE = 8'h0A;
   localparam logic [6:0]       CAP_MAX      = 7'(MAX_CHUNK + 1);
   localparam logic [3:0]       PAT_MAX      = 4'(MAX_PATTERN);

   // Request opcodes
   typedef enum logic [1:0] {
      OP_RECV   = 2'd0,
      OP_CHUNK  = 2'd1,
      OP_SEARCH = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  rx_byte;
      logic [6:0]  max_len;
      logic [63:0] pattern_bytes;
      logic [3:0]  pattern_len;
   } req_type;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             data_valid;
      logic             last;
      logic [6:0]       chunk_count;
      logic             found;
      logic             line_end;
      logic             dropped;
      logic [CNT_W-1:0] fill_level;
   } rsp_type;

   // Microcode step addresses
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE        = 3'd0;
   localparam logic [STEP_W-1:0] STEP_APPEND      = 3'd1;
   localparam logic [STEP_W-1:0] STEP_CHUNK_SETUP = 3'd2;
   localparam logic [STEP_W-1:0] STEP_CHUNK_LOOP  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_SRCH_SETUP  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_SRCH_LOOP   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_CLEAR       = 3'd6;

   // Datapath operation of one step
   typedef enum logic [2:0] {
      DP_NONE        = 3'd0,
      DP_APPEND      = 3'd1,
      DP_CHUNK_SETUP = 3'd2,
      DP_CHUNK_STEP  = 3'd3,
      DP_SRCH_SETUP  = 3'd4,
      DP_SRCH_STEP   = 3'd5,
      DP_CLEAR       = 3'd6
   } dp_op_type;

   // When a step issues a result
   typedef enum logic [1:0] {
      EM_NONE   = 2'd0,
      EM_ALWAYS = 2'd1,
      EM_COND   = 2'd2
   } emit_type;

   // How the step counter advances
   typedef enum logic [1:0] {
      SQ_JUMP     = 2'd0,
      SQ_DISPATCH = 2'd1,
      SQ_BR_NEXT  = 2'd2,
      SQ_BR_STAY  = 2'd3
   } seq_type;

   // Branch condition select
   typedef enum logic [2:0] {
      C_NONE        = 3'd0,
      C_CHUNK_EMPTY = 3'd1,
      C_CHUNK_END   = 3'd2,
      C_SRCH_SKIP   = 3'd3,
      C_SRCH_END    = 3'd4
   } cond_type;

   typedef struct packed {
      dp_op_type         op;
      emit_type          emit;
      seq_type           seq;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctl_word_type;

   // Control store
   function automatic ctl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      case (step)
         STEP_IDLE:        w = '{DP_NONE,        EM_NONE,   SQ_DISPATCH, C_NONE,        STEP_IDLE};
         STEP_APPEND:      w = '{DP_APPEND,      EM_ALWAYS, SQ_JUMP,     C_NONE,        STEP_IDLE};
         STEP_CHUNK_SETUP: w = '{DP_CHUNK_SETUP, EM_COND,   SQ_BR_NEXT,  C_CHUNK_EMPTY, STEP_IDLE};
         STEP_CHUNK_LOOP:  w = '{DP_CHUNK_STEP,  EM_ALWAYS, SQ_BR_STAY,  C_CHUNK_END,   STEP_IDLE};
         STEP_SRCH_SETUP:  w = '{DP_SRCH_SETUP,  EM_COND,   SQ_BR_NEXT,  C_SRCH_SKIP,   STEP_IDLE};
         STEP_SRCH_LOOP:   w = '{DP_SRCH_STEP,   EM_COND,   SQ_BR_STAY,  C_SRCH_END,    STEP_IDLE};
         STEP_CLEAR:       w = '{DP_CLEAR,       EM_ALWAYS, SQ_JUMP,     C_NONE,        STEP_IDLE};
         default:          w = '{DP_NONE,        EM_NONE,   SQ_JUMP,     C_NONE,        STEP_IDLE};
      endcase
      return w;
   endfunction

   // Entry step of each opcode
   function automatic logic [STEP_W-1:0] dispatch_rom(input logic [1:0] opcode);
      logic [STEP_W-1:0] s;
      case (opcode)
         OP_RECV:   s = STEP_APPEND;
         OP_CHUNK:  s = STEP_CHUNK_SETUP;
         OP_SEARCH: s = STEP_SRCH_SETUP;
         OP_CLEAR:  s = STEP_CLEAR;
         default:   s = STEP_IDLE;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

### rtl/core/rbpm_seq.sv
`default_nettype none

module rbpm_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           opcode,
   input  wire logic                 cond_hit,
   output rbpm_pkg::ctl_word_type    ctl,
   output logic                      busy,
   output logic                      accept
);
   import rbpm_pkg::*;

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;

   // Fetch the control word of the current step
   assign ctl    = ucode_rom(upc_ff);
   assign busy   = (upc_ff != STEP_IDLE);
   assign accept = start && !busy;

   // Select the next step
   always_comb begin
      case (ctl.seq)
         SQ_JUMP:     upc_in = ctl.target;
         SQ_DISPATCH: upc_in = accept ? dispatch_rom(opcode) : upc_ff;
         SQ_BR_NEXT:  upc_in = cond_hit ? ctl.target : upc_ff + STEP_W'(1);
         SQ_BR_STAY:  upc_in = cond_hit ? ctl.target : upc_ff;
         default:     upc_in = STEP_IDLE;
      endcase
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/rx_buffer_pattern_match.sv
`default_nettype none

// Each step's result is registered. Receive, clear, an empty chunk and a skipped search
// answer from their first step; a chunk's bytes follow its setup step, one per cycle, and
// a search answers on a match or at the fill count (one store read per cycle). No new
// request is taken until the sequencer is idle again. Results cannot be stalled. Reset
// clears the fill count, read pointer, sequencer and result strobe; the byte store is
// not cleared and only its bytes below the fill count are ever used.
module rx_buffer_pattern_match (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire rbpm_pkg::req_type req_data,
   output logic                   rsp_valid,
   output rbpm_pkg::rsp_type      rsp_data
);
   import rbpm_pkg::*;

   ctl_word_type ctl;
   logic         accept;
   logic         cond_hit;

   req_type           req_ff, req_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [6:0]        n_ff, n_in;
   logic [63:0]       win_ff, win_in;
   logic [7:0]        rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   logic [7:0]   store_mem [BUF_DEPTH];

   logic [6:0]   cap;
   logic [6:0]   n_calc;
   logic [3:0]   plen;
   logic [63:0]  win_nx;
   logic [7:0]   eq_vec;
   logic         match;
   logic         room;

   rbpm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .opcode   (req_data.opcode),
      .cond_hit (cond_hit),
      .ctl      (ctl),
      .busy     (busy),
      .accept   (accept)
   );

   // Clamp drain capacity and size the chunk
   always_comb begin
      if (req_ff.max_len == 7'd0) begin
         cap = 7'd1;
      end else if (req_ff.max_len > CAP_MAX) begin
         cap = CAP_MAX;
      end else begin
         cap = req_ff.max_len;
      end
      if (count_ff < {2'b00, cap}) begin
         n_calc = count_ff[6:0];
      end else begin
         n_calc = cap - 7'd1;
      end
   end

   // Compare the newest window bytes against the pattern, newest to last pattern byte
   assign plen   = (req_ff.pattern_len > PAT_MAX) ? PAT_MAX : req_ff.pattern_len;
   assign win_nx = {win_ff[55:0], rd_data_ff};

   always_comb begin
      logic [2:0] pj;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pj = 3'(plen - 4'd1 - 4'(j));
         eq_vec[j] = (4'(j) >= plen) ||
                     (win_nx[8*j +: 8] == req_ff.pattern_bytes[8*pj +: 8]);
      end
   end

   assign match = (&eq_vec) && (idx_ff >= {5'd0, plen});
   assign room  = (count_ff < FULL_LEVEL);

   // Evaluate the branch condition
   always_comb begin
      case (ctl.cond)
         C_NONE:        cond_hit = 1'b0;
         C_CHUNK_EMPTY: cond_hit = (n_calc == 7'd0);
         C_CHUNK_END:   cond_hit = (idx_ff == {2'b00, n_ff});
         C_SRCH_SKIP:   cond_hit = (plen == 4'd0) || (count_ff < {5'd0, plen});
         C_SRCH_END:    cond_hit = match || (idx_ff == count_ff);
         default:       cond_hit = 1'b0;
      endcase
   end

   // Datapath actions of the current step
   always_comb begin
      req_in   = accept ? req_data : req_ff;
      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      win_in   = win_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff + count_ff[ADDR_W-1:0];
      rd_en    = 1'b0;
      rd_addr  = head_ff + idx_ff[ADDR_W-1:0];
      rsp_in   = '0;
      rsp_in.last = 1'b1;

      case (ctl.op)
         DP_NONE: begin
         end
         DP_APPEND: begin
            if (room) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            rsp_in.line_end = (req_ff.rx_byte == NEWLINE_CODE);
            rsp_in.dropped  = !room;
         end
         DP_CHUNK_SETUP: begin
            n_in     = n_calc;
            count_in = count_ff - {2'b00, n_calc};
            idx_in   = CNT_W'(1);
            rd_en    = 1'b1;
            rd_addr  = head_ff;
         end
         DP_CHUNK_STEP: begin
            rd_en  = 1'b1;
            idx_in = idx_ff + CNT_W'(1);
            rsp_in.data_byte   = rd_data_ff;
            rsp_in.data_valid  = 1'b1;
            rsp_in.last        = cond_hit;
            rsp_in.chunk_count = n_ff;
            if (cond_hit) begin
               head_in = head_ff + {2'b00, n_ff};
            end
         end
         DP_SRCH_SETUP: begin
            idx_in  = CNT_W'(1);
            win_in  = '0;
            rd_en   = 1'b1;
            rd_addr = head_ff;
            rsp_in.found = (plen == 4'd0);
         end
         DP_SRCH_STEP: begin
            win_in = win_nx;
            rd_en  = 1'b1;
            idx_in = idx_ff + CNT_W'(1);
            rsp_in.found = match;
            if (match) begin
               head_in  = head_ff + idx_ff[ADDR_W-1:0];
               count_in = count_ff - idx_ff;
            end
         end
         DP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase

      rsp_in.fill_level = count_in;
      rsp_valid_in = (ctl.emit == EM_ALWAYS) || ((ctl.emit == EM_COND) && cond_hit);
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req_ff.rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload state
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      n_ff   <= n_in;
      win_ff <= win_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Fill never passes the drop threshold
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_LEVEL)
      else $error("fill count above buffer limit");

   // A request transfer always occupies the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("sequencer idle after request transfer");

   // The final result is never followed at once by another
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result directly after final result");

   // Drained bytes carry a nonzero chunk size within range
   a_chunk_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.data_valid |->
         (rsp_data.chunk_count != 7'd0) && (rsp_data.chunk_count <= 7'(MAX_CHUNK)))
      else $error("drained byte with bad chunk size");

endmodule

`default_nettype wire
